// ===== design/adp_pkg.sv =====
// Shared types, constants and functions of the anisotropic diffusion pass core.
// It depends on nothing else and comes first in the compile order.
package adp_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_STEP_GAIN    = 2'd2;

  // Input action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Write enables of the two line buffers.
  typedef struct packed {
    logic orig_we;
    logic upd_we;
  } mem_wr_t;

  // Conductance exp(-t) for t in Q16, built by sixteen squarings of (1 - t/2^16).
  function automatic logic [PIX_W-1:0] cond_entry(input logic [63:0] t);
    logic [64:0] a;
    logic [64:0] r;
    if (t == 64'd0) begin
      return {PIX_W{1'b1}};
    end
    if (t >= (64'd24 << 16)) begin
      return '0;
    end
    a = (65'd1 << 32) - {1'b0, t};
    for (int i = 0; i < 16; i++) begin
      a = (a * a + (65'd1 << 31)) >> 32;
    end
    r = (a + 65'd32768) >> 16;
    return (r > 65'd65535) ? {PIX_W{1'b1}} : r[PIX_W-1:0];
  endfunction

endpackage

// ===== design/adp_if.sv =====
// Valid/ready stream interfaces for the pixel input and the result output.
// They depend on adp_pkg for the pixel width.
interface adp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [adp_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, output action, output pixel_in, input ready);
  modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface adp_out_if;
  logic                     valid;
  logic                     ready;
  logic [adp_pkg::PIX_W-1:0] pixel_out;
  logic                     frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== design/adp_line_mem.sv =====
// Line buffers of the original and the updated previous row.
// Depends on adp_pkg; reads are registered.
module adp_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk_i,
  input  adp_pkg::mem_wr_t          wr_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [adp_pkg::PIX_W-1:0] orig_wdata_i,
  input  logic [adp_pkg::PIX_W-1:0] upd_wdata_i,
  input  logic [AW-1:0]             orig_raddr_a_i,
  input  logic [AW-1:0]             orig_raddr_b_i,
  input  logic [AW-1:0]             upd_raddr_i,
  output logic [adp_pkg::PIX_W-1:0] orig_rdata_a_o,
  output logic [adp_pkg::PIX_W-1:0] orig_rdata_b_o,
  output logic [adp_pkg::PIX_W-1:0] upd_rdata_o
);
  import adp_pkg::*;

  logic [PIX_W-1:0] orig_mem [DEPTH];
  logic [PIX_W-1:0] upd_mem  [DEPTH];

  // Original row: one write port, two read ports.
  always_ff @(posedge clk_i) begin
    if (wr_i.orig_we) begin
      orig_mem[waddr_i] <= orig_wdata_i;
    end
    orig_rdata_a_o <= orig_mem[orig_raddr_a_i];
    orig_rdata_b_o <= orig_mem[orig_raddr_b_i];
  end

  // Updated row: one write port, one read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.upd_we) begin
      upd_mem[waddr_i] <= upd_wdata_i;
    end
    upd_rdata_o <= upd_mem[upd_raddr_i];
  end

endmodule

// ===== design/adp_term.sv =====
// Conductance term g(|d|>>4) * d for one neighbor, with the table built at elaboration.
// Depends on adp_pkg for the table entry function.
module adp_term #(
  parameter int unsigned KAPPA         = 983,
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic [adp_pkg::PIX_W-1:0]        nb_i,
  input  logic [adp_pkg::PIX_W-1:0]        ctr_i,
  output logic signed [adp_pkg::PIX_W+16:0] term_o
);
  import adp_pkg::*;

  localparam int unsigned KW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [63:0] KK = 64'(KAPPA) * 64'(KAPPA);

  logic [PIX_W-1:0] cond_tab [TABLE_ENTRIES];

  // One constant entry per table index.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_tab
    localparam logic [63:0] TQ = ((64'd256 * 64'(k) * 64'(k)) << 16) / KK;
    assign cond_tab[k] = cond_entry(TQ);
  end

  logic signed [PIX_W:0] diff;
  logic [PIX_W-1:0]      mag;
  logic [PIX_W-5:0]      tidx;
  logic [PIX_W-1:0]      cond;

  // Difference, magnitude and table lookup; indexes past the table give zero.
  always_comb begin
    diff = $signed({1'b0, nb_i}) - $signed({1'b0, ctr_i});
    mag  = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
    tidx = mag[PIX_W-1:4];
    if (32'(tidx) < TABLE_ENTRIES) begin
      cond = cond_tab[tidx[KW-1:0]];
    end else begin
      cond = '0;
    end
    term_o = $signed({1'b0, cond}) * diff;
  end

endmodule

// ===== design/anisotropic_diffusion_pass_core.sv =====
// Top level of one in-place Perona-Malik diffusion pass over a raster pixel stream.
// Depends on adp_pkg, adp_if, adp_line_mem and adp_term.
//
//  channel   direction  payload                     transaction
//  in_ch     sink       action, pixel_in            valid && ready
//  out_ch    source     pixel_out, frame_end        valid && ready
//  cfg       write      cfg_we_i, cfg_idx_i, data   cfg_we_i high
//
// A first-row pixel is only written to the line buffer. An interior pixel goes through
// acceptance, a line buffer read, four conductance terms through one shared multiplier,
// the gain multiply, saturation and write-back. Border pixels and flushes skip the math.
// Reset clears the counters and the left neighbor; the line buffers need no clearing.
// A full output register holds the sequencer in its write-back step until taken.
module anisotropic_diffusion_pass_core #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned KAPPA         = 983,
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [adp_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [adp_pkg::CFG_DW-1:0] cfg_data_i,
  adp_in_if.sink                     in_ch,
  adp_out_if.source                  out_ch
);
  import adp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned CW = (WW > 11) ? WW : 11;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_TERM = 3'd2;
  localparam logic [2:0] ST_GAIN = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // Configuration registers.
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [8:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 16'd1024;
      gain_q   <= 9'd102;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[15:0];
        CFG_STEP_GAIN:    gain_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective width and height after clamping.
  logic [CW-1:0] eff_w;
  logic [15:0]   eff_h;

  always_comb begin
    eff_w = CW'(width_q);
    if (eff_w < CW'(3)) begin
      eff_w = CW'(3);
    end else if (eff_w > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
  end

  // Sequencer and datapath registers.
  logic [2:0]                  state_q, state_d;
  logic                        act_q;
  logic [PIX_W-1:0]            pix_q, ctr_q, up_q, right_q, left_q, y_q;
  logic [1:0]                  idx_q;
  logic signed [PIX_W+18:0]    acc_q;
  logic signed [PIX_W+29:0]    gp_q;
  logic [AW-1:0]               col_q, flush_q;
  logic [15:0]                 row_q;
  logic                        ov_q, fe_q;
  logic [PIX_W-1:0]            po_q;

  logic [PIX_W-1:0] orig_a, orig_b, upd_rd;
  mem_wr_t          mem_wr;
  logic [AW-1:0]    waddr;
  logic [PIX_W-1:0] orig_wdata;

  logic [PIX_W-1:0]         nb;
  logic signed [PIX_W+16:0] term;

  logic in_acc, take, col_last, flush_last, emit_go;
  logic [CW-1:0] col_next, flush_next;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign take        = (in_ch.action == ACT_FLUSH) ? (row_q >= eff_h) : (row_q < eff_h);
  assign col_next    = CW'(col_q) + CW'(1);
  assign flush_next  = CW'(flush_q) + CW'(1);
  assign col_last    = col_next >= eff_w;
  assign flush_last  = flush_next >= eff_w;
  assign emit_go     = (state_q == ST_EMIT) && (!ov_q || out_ch.ready);

  // Line buffer writes: a first-row pixel at acceptance, any other pixel at write-back.
  always_comb begin
    mem_wr.orig_we = 1'b0;
    mem_wr.upd_we  = 1'b0;
    orig_wdata     = pix_q;
    waddr          = col_q;
    if (in_acc && take && in_ch.action == ACT_PIXEL && row_q == 16'd0) begin
      mem_wr.orig_we = 1'b1;
      orig_wdata     = in_ch.pixel_in;
    end else if (emit_go && act_q == ACT_PIXEL) begin
      mem_wr.orig_we = 1'b1;
      mem_wr.upd_we  = 1'b1;
    end
  end

  adp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i          (clk_i),
    .wr_i           (mem_wr),
    .waddr_i        (waddr),
    .orig_wdata_i   (orig_wdata),
    .upd_wdata_i    (y_q),
    .orig_raddr_a_i ((in_ch.action == ACT_FLUSH && state_q == ST_IDLE) ? flush_q : col_q),
    .orig_raddr_b_i (col_next[AW-1:0]),
    .upd_raddr_i    (col_q),
    .orig_rdata_a_o (orig_a),
    .orig_rdata_b_o (orig_b),
    .upd_rdata_o    (upd_rd)
  );

  // Neighbor selection for the shared term unit: up, left, right, down.
  always_comb begin
    unique case (idx_q)
      2'd0:    nb = up_q;
      2'd1:    nb = left_q;
      2'd2:    nb = right_q;
      default: nb = pix_q;
    endcase
  end

  adp_term #(
    .KAPPA         (KAPPA),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_term (
    .nb_i   (nb),
    .ctr_i  (ctr_q),
    .term_o (term)
  );

  // Rounded gain step added to the center, then saturated.
  logic signed [PIX_W+3:0] step;
  logic signed [PIX_W+4:0] sum_v;
  logic [PIX_W-1:0]        sat_v;

  always_comb begin
    step  = gp_q[PIX_W+29:26];
    sum_v = $signed({5'd0, ctr_q}) + (PIX_W+5)'(step);
    if (sum_v < 0) begin
      sat_v = '0;
    end else if (sum_v > $signed((PIX_W+5)'(65535))) begin
      sat_v = {PIX_W{1'b1}};
    end else begin
      sat_v = sum_v[PIX_W-1:0];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && take && !(in_ch.action == ACT_PIXEL && row_q == 16'd0)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (act_q == ACT_FLUSH || row_q == 16'd1 || col_q == '0 || col_last) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_TERM: if (idx_q == 2'd3) state_d = ST_GAIN;
      ST_GAIN: state_d = ST_SAT;
      ST_SAT:  state_d = ST_EMIT;
      ST_EMIT: if (emit_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state: sequencer, counters, left neighbor and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
      left_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ch.ready) begin
        ov_q <= 1'b0;
      end
      if (in_acc && take && in_ch.action == ACT_PIXEL && row_q == 16'd0) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + 16'd1;
        end else begin
          col_q <= col_next[AW-1:0];
        end
      end
      if (emit_go) begin
        if (act_q == ACT_FLUSH) begin
          if (flush_last) begin
            col_q   <= '0;
            row_q   <= '0;
            flush_q <= '0;
            left_q  <= '0;
          end else begin
            flush_q <= flush_next[AW-1:0];
          end
        end else begin
          left_q <= y_q;
          if (col_last) begin
            col_q <= '0;
            row_q <= row_q + 16'd1;
          end else begin
            col_q <= col_next[AW-1:0];
          end
        end
      end
    end
  end

  // Payload registers of the datapath and the output.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= in_ch.action;
      pix_q <= in_ch.pixel_in;
    end
    unique case (state_q)
      ST_LOAD: begin
        ctr_q   <= orig_a;
        up_q    <= upd_rd;
        right_q <= orig_b;
        y_q     <= orig_a;
        acc_q   <= '0;
        idx_q   <= 2'd0;
      end
      ST_TERM: begin
        acc_q <= acc_q + (PIX_W+19)'(term);
        idx_q <= idx_q + 2'd1;
      end
      ST_GAIN: begin
        gp_q <= $signed({1'b0, gain_q}) * acc_q + $signed((PIX_W+30)'(64'd1 << 25));
      end
      ST_SAT: y_q <= sat_v;
      default: ;
    endcase
    if (emit_go) begin
      po_q <= y_q;
      fe_q <= (act_q == ACT_FLUSH) && flush_last;
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.pixel_out = po_q;
  assign out_ch.frame_end = fe_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the anisotropic diffusion pass core.
// Depends on adp_pkg, adp_if and the core; it predicts every result on its own.
module tb_top;
  import adp_pkg::*;

  localparam int unsigned LINE_MAX   = 1024;
  localparam int unsigned KAPPA_VAL  = 983;
  localparam int unsigned LUT_SIZE   = 256;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned DRAIN_WAIT = 40;

  // Pixel content styles of a frame.
  typedef enum int {
    FILL_SMOOTH, FILL_RANDOM, FILL_HIGH_PLATEAU, FILL_LOW_PLATEAU, FILL_EXTREMES
  } fill_style_e;

  typedef struct {
    bit [PIX_W-1:0] pix;
    bit             last;
  } pixel_result_t;

  // Scoreboard: keeps its own copy of the line buffers and counters and
  // queues the diffused pixels the core should emit.
  class diffusion_scoreboard;
    bit [PIX_W-1:0]  cond_lut[LUT_SIZE];
    bit [PIX_W-1:0]  orig_line[LINE_MAX];
    bit [PIX_W-1:0]  upd_line[LINE_MAX];
    bit [PIX_W-1:0]  left_pix;
    int unsigned     col, row, flush_col;
    bit [10:0]       width_reg;
    bit [15:0]       height_reg;
    bit [8:0]        gain_reg;
    pixel_result_t   pending[$];
    int unsigned     errors, pixels_taken, results_seen, ignored_seen;

    function new();
      for (int unsigned k = 0; k < LUT_SIZE; k++) begin
        cond_lut[k] = lut_value(k);
      end
      width_reg = 11'd1024;
      height_reg = 16'd1024;
      gain_reg = 9'd102;
    endfunction

    // exp(-(16k/kappa)^2) by repeated squaring of (1 - t) in Q32.
    function bit [PIX_W-1:0] lut_value(int unsigned k);
      bit [127:0]      acc;
      longint unsigned t;
      t = ((longint'(256) * k * k) << 16) / (longint'(KAPPA_VAL) * KAPPA_VAL);
      if (t == 0) return 16'hFFFF;
      if (t >= (longint'(24) << 16)) return 16'h0000;
      acc = (128'd1 << 32) - t;
      repeat (16) acc = (acc * acc + (128'd1 << 31)) >> 32;
      acc = (acc + 128'd32768) >> 16;
      return (acc > 128'd65535) ? 16'hFFFF : acc[PIX_W-1:0];
    endfunction

    function longint flux(bit [PIX_W-1:0] nb, bit [PIX_W-1:0] ctr);
      longint      d;
      longint      mag;
      longint      g;
      d = longint'(nb) - longint'(ctr);
      mag = (d < 0) ? -d : d;
      g = ((mag >> 4) < LUT_SIZE) ? longint'(cond_lut[mag >> 4]) : 0;
      return g * d;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, bit [CFG_DW-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH: width_reg = val[10:0];
        CFG_IMAGE_HEIGHT: height_reg = val;
        CFG_STEP_GAIN: gain_reg = val[8:0];
        default: ;
      endcase
    endfunction

    // Note one accepted input transaction and queue what it produces.
    function void note_input(bit act, bit [PIX_W-1:0] p);
      int unsigned   w;
      int unsigned   h;
      bit [PIX_W-1:0] ctr;
      bit [PIX_W-1:0] y;
      longint        s;
      longint        v;
      pixel_result_t r;
      w = eff_width();
      h = eff_height();
      if (act == ACT_PIXEL) begin
        if (row >= h) begin
          ignored_seen++;
          return;
        end
        pixels_taken++;
        if (row > 0) begin
          ctr = orig_line[col];
          if (row == 1 || col == 0 || col + 1 >= w) begin
            y = ctr;
          end else begin
            s = flux(upd_line[col], ctr) + flux(left_pix, ctr)
              + flux(orig_line[col + 1], ctr) + flux(p, ctr);
            v = longint'(ctr) + ((longint'(gain_reg) * s + (longint'(1) << 25)) >>> 26);
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            y = v[PIX_W-1:0];
          end
          upd_line[col] = y;
          left_pix = y;
          r.pix = y;
          r.last = 1'b0;
          pending.push_back(r);
        end
        orig_line[col] = p;
        if (col + 1 >= w) begin
          col = 0;
          row++;
        end else begin
          col++;
        end
      end else begin
        if (row < h) begin
          ignored_seen++;
          return;
        end
        pixels_taken++;
        r.pix = orig_line[flush_col];
        r.last = (flush_col + 1 >= w);
        pending.push_back(r);
        if (r.last) begin
          left_pix = '0;
          col = 0;
          row = 0;
          flush_col = 0;
        end else begin
          flush_col++;
        end
      end
    endfunction

    function void report(string msg);
      $display("MISMATCH %s", msg);
      errors++;
    endfunction

    // Compare one output transaction with the oldest expectation.
    function void check_result(bit [PIX_W-1:0] p, bit last);
      pixel_result_t r;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result pixel_out=%0d frame_end=%0b", p, last));
        return;
      end
      r = pending.pop_front();
      if (p !== r.pix)
        report($sformatf("result %0d: pixel_out=%0d, predicted %0d", results_seen, p, r.pix));
      if (last !== r.last)
        report($sformatf("result %0d: frame_end=%0b, predicted %0b", results_seen, last, r.last));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_idx_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  bit                  quiet;
  int unsigned         cycles;
  diffusion_scoreboard sb;

  adp_in_if  in_if ();
  adp_out_if out_if ();

  anisotropic_diffusion_pass_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Output side: check each result transaction and stall now and then.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.pixel_out, out_if.frame_end);
      out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  // Send one input transaction, at times with a random gap in front of it.
  task automatic send(bit act, bit [PIX_W-1:0] p);
    if (!quiet && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.pixel_in <= p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(act, p);
  endtask

  // Stop sending and let every queued result come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, bit [CFG_DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  function automatic bit [PIX_W-1:0] pick_pixel(fill_style_e style, int unsigned r,
                                                int unsigned c, int unsigned w,
                                                bit [PIX_W-1:0] base);
    bit inner;
    int v;
    inner = (r == 1) && (c > 0) && (c + 1 < w);
    case (style)
      FILL_SMOOTH: begin
        v = int'(base) + $urandom_range(0, 2400) - 1200;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[PIX_W-1:0];
      end
      FILL_HIGH_PLATEAU: return inner ? 16'(65000 + $urandom_range(0, 300)) : 16'hFFFF;
      FILL_LOW_PLATEAU: return inner ? 16'($urandom_range(300, 600)) : 16'h0000;
      FILL_EXTREMES: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // One whole frame: settle, configure, stream the pixels, flush the bottom row.
  // Noise adds early flushes and surplus pixels, which the core must ignore.
  task automatic run_frame(bit [CFG_DW-1:0] wcfg, bit [CFG_DW-1:0] hcfg,
                           bit [CFG_DW-1:0] gain, fill_style_e style, bit noise,
                           bit hold_mid);
    int unsigned    w;
    int unsigned    h;
    bit [PIX_W-1:0] base;
    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    write_reg(CFG_IMAGE_WIDTH, wcfg);
    write_reg(CFG_IMAGE_HEIGHT, hcfg);
    write_reg(CFG_STEP_GAIN, gain);
    cfg_we_i <= 1'b0;
    w = sb.eff_width();
    h = sb.eff_height();
    base = 16'($urandom());
    for (int unsigned r = 0; r < h; r++) begin
      if (hold_mid && r == h / 2) drain();
      for (int unsigned c = 0; c < w; c++) begin
        if (noise && $urandom_range(99) < 3) send(ACT_FLUSH, 16'($urandom()));
        send(ACT_PIXEL, pick_pixel(style, r, c, w, base));
      end
    end
    if (noise) repeat ($urandom_range(1, 3)) send(ACT_PIXEL, 16'($urandom()));
    for (int unsigned c = 0; c < w; c++) send(ACT_FLUSH, 16'($urandom()));
  endtask

  // Main stimulus sequence.
  initial begin
    int unsigned    frames;
    bit [CFG_DW-1:0] wcfg;
    bit [CFG_DW-1:0] hcfg;
    bit [CFG_DW-1:0] gain;
    sb = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_IMAGE_WIDTH;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_PIXEL;
    in_if.pixel_in <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest frame with extreme values, saturation both ways,
    // clamped register values and a flush before the frame is complete.
    quiet = 1'b1;
    run_frame(16'd3, 16'd3, 16'd256, FILL_EXTREMES, 1'b1, 1'b0);
    run_frame(16'd4, 16'd3, 16'd511, FILL_HIGH_PLATEAU, 1'b0, 1'b0);
    run_frame(16'd4, 16'd3, 16'd511, FILL_LOW_PLATEAU, 1'b0, 1'b0);
    quiet = 1'b0;
    run_frame(16'd0, 16'd1, 16'd0, FILL_RANDOM, 1'b0, 1'b0);

    // A long line of smooth content.
    run_frame(16'd256, 16'd3, 16'd102, FILL_SMOOTH, 1'b0, 1'b0);

    // Random frames, mostly small.
    frames = 0;
    while (sb.pixels_taken < 1600) begin
      wcfg = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 64))
                                      : 16'($urandom_range(2, 12));
      hcfg = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 2))
                                      : 16'($urandom_range(3, 8));
      case ($urandom_range(5))
        0: gain = 16'd0;
        1: gain = 16'd256;
        2: gain = 16'd511;
        default: gain = 16'($urandom_range(0, 511));
      endcase
      quiet = (frames >= 10 && frames < 16);
      run_frame(wcfg, hcfg, gain,
                ($urandom_range(3) == 0) ? FILL_RANDOM : FILL_SMOOTH,
                $urandom_range(3) == 0, frames == 5);
      frames++;
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("tb_top: %0d frames, %0d pixel and flush transactions, %0d ignored, %0d results",
             frames + 5, sb.pixels_taken, sb.ignored_seen, sb.results_seen);
    $display("tb_top: widths 3 to 256, gains 0 to 511, saturation and border cases covered");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
